>>> rtl/gpsb_pkg.sv
// Shared types, register codes and constants of the gradient point selector.
package gpsb_pkg;

   // Default sizes handed to the top level parameters
   localparam int MAX_WIDTH_DEF  = 1024;
   localparam int BORDER_DEF     = 10;
   localparam int DEPTH_BITS_DEF = 16;

   // Row counter and frame height limit
   localparam int ROW_W     = 10;
   localparam int HEIGHT_W  = 11;
   localparam int ROW_LIMIT = 1024;

   // Configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_GRAD_THRESHOLD   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_CENTER_X_Q4      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_CENTER_Y_Q4      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_INV_FOCAL_X_Q24  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_INV_FOCAL_Y_Q24  = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_INV_DEPTH_SCALE  = 3'd7;

   localparam logic [10:0] IMAGE_WIDTH_RST     = 11'd640;
   localparam logic [10:0] IMAGE_HEIGHT_RST    = 11'd480;
   localparam logic [8:0]  GRAD_THRESHOLD_RST  = 9'd50;
   localparam logic [13:0] CENTER_X_RST        = 14'd5208;
   localparam logic [13:0] CENTER_Y_RST        = 14'd4056;
   localparam logic [23:0] INV_FOCAL_X_RST     = 24'd32388;
   localparam logic [23:0] INV_FOCAL_Y_RST     = 24'd32326;
   localparam logic [23:0] INV_DEPTH_SCALE_RST = 24'd16777;

   // Fixed point widths
   localparam int Z_W     = 23;
   localparam int XY_W    = 24;
   localparam int D_MAG_W = 16;
   localparam int FOC_W   = 24;
   localparam int FH_W    = 12;
   localparam int ZD_W    = Z_W + D_MAG_W;
   localparam int PP_W    = ZD_W + FH_W;
   localparam int SUM_W   = PP_W + 1;
   localparam int MAG_W   = SUM_W - 16;

   localparam logic [Z_W-1:0]   Z_MAX      = 23'h7FFFFF;
   localparam logic [XY_W-1:0]  XY_POS_MAX = 24'h7FFFFF;
   localparam logic [XY_W-1:0]  XY_NEG_MAX = 24'h800000;

   typedef struct packed {
      logic [7:0]  gray_value;
      logic [15:0] depth_raw;
      logic        frame_start;
   } req_type;

   typedef struct packed {
      logic [9:0]             pixel_col;
      logic [9:0]             pixel_row;
      logic signed [XY_W-1:0] point_x_q16;
      logic signed [XY_W-1:0] point_y_q16;
      logic [Z_W-1:0]         point_z_q16;
      logic [7:0]             pixel_gray;
   } rsp_type;

   // Selected pixel handed to the back-projection pipeline
   typedef struct packed {
      logic [9:0]         pixel_col;
      logic [9:0]         pixel_row;
      logic [7:0]         pixel_gray;
      logic [Z_W-1:0]     z;
      logic [D_MAG_W-1:0] du_mag;
      logic               du_neg;
      logic [D_MAG_W-1:0] dv_mag;
      logic               dv_neg;
   } proj_type;

endpackage

>>> rtl/gpsb_project.sv
// Pinhole back-projection pipeline: z times offset times inverse focal length.
module gpsb_project (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   output logic                                in_stall,
   input  gpsb_pkg::proj_type                  in_data,
   output logic                                out_valid,
   input  logic                                out_stall,
   output gpsb_pkg::rsp_type                   out_data,
   input  logic [gpsb_pkg::FOC_W-1:0]          inv_focal_x_q24,
   input  logic [gpsb_pkg::FOC_W-1:0]          inv_focal_y_q24
);

   // p0: input
   logic                 p0_v_ff;
   gpsb_pkg::proj_type   p0_ff;
   // p1: z times offset
   logic                 p1_v_ff;
   gpsb_pkg::proj_type   p1_ff;
   logic [gpsb_pkg::ZD_W-1:0] p1_zdx_ff, p1_zdy_ff;
   // p2: partial products with the focal halves
   logic                 p2_v_ff;
   gpsb_pkg::proj_type   p2_ff;
   logic [gpsb_pkg::PP_W-1:0] p2_xlo_ff, p2_xhi_ff, p2_ylo_ff, p2_yhi_ff;
   // p3: magnitudes
   logic                 p3_v_ff;
   gpsb_pkg::proj_type   p3_ff;
   logic [gpsb_pkg::MAG_W-1:0] p3_magx_ff, p3_magy_ff;
   // p4: output
   logic                 p4_v_ff;
   gpsb_pkg::rsp_type    p4_ff;

   logic p0_ready, p1_ready, p2_ready, p3_ready, p4_ready;
   logic [gpsb_pkg::SUM_W-1:0] sumx_in, sumy_in;
   logic [gpsb_pkg::XY_W-1:0]  x_in, y_in;

   assign p4_ready = !p4_v_ff || !out_stall;
   assign p3_ready = !p3_v_ff || p4_ready;
   assign p2_ready = !p2_v_ff || p3_ready;
   assign p1_ready = !p1_v_ff || p2_ready;
   assign p0_ready = !p0_v_ff || p1_ready;
   assign in_stall = !p0_ready;

   // floor((lo + hi * 2^12) / 2^28) taken as floor((lo / 2^12 + hi) / 2^16)
   assign sumx_in = gpsb_pkg::SUM_W'(p2_xlo_ff >> gpsb_pkg::FH_W)
                  + gpsb_pkg::SUM_W'(p2_xhi_ff);
   assign sumy_in = gpsb_pkg::SUM_W'(p2_ylo_ff >> gpsb_pkg::FH_W)
                  + gpsb_pkg::SUM_W'(p2_yhi_ff);

   always_comb begin
      if (p3_ff.du_neg) begin
         if (p3_magx_ff > gpsb_pkg::MAG_W'(gpsb_pkg::XY_NEG_MAX)) begin
            x_in = gpsb_pkg::XY_NEG_MAX;
         end else begin
            x_in = gpsb_pkg::XY_W'(0) - p3_magx_ff[gpsb_pkg::XY_W-1:0];
         end
      end else begin
         if (p3_magx_ff > gpsb_pkg::MAG_W'(gpsb_pkg::XY_POS_MAX)) begin
            x_in = gpsb_pkg::XY_POS_MAX;
         end else begin
            x_in = p3_magx_ff[gpsb_pkg::XY_W-1:0];
         end
      end
      if (p3_ff.dv_neg) begin
         if (p3_magy_ff > gpsb_pkg::MAG_W'(gpsb_pkg::XY_NEG_MAX)) begin
            y_in = gpsb_pkg::XY_NEG_MAX;
         end else begin
            y_in = gpsb_pkg::XY_W'(0) - p3_magy_ff[gpsb_pkg::XY_W-1:0];
         end
      end else begin
         if (p3_magy_ff > gpsb_pkg::MAG_W'(gpsb_pkg::XY_POS_MAX)) begin
            y_in = gpsb_pkg::XY_POS_MAX;
         end else begin
            y_in = p3_magy_ff[gpsb_pkg::XY_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p0_v_ff <= 1'b0;
         p1_v_ff <= 1'b0;
         p2_v_ff <= 1'b0;
         p3_v_ff <= 1'b0;
         p4_v_ff <= 1'b0;
      end else begin
         if (p0_ready) p0_v_ff <= in_valid;
         if (p1_ready) p1_v_ff <= p0_v_ff;
         if (p2_ready) p2_v_ff <= p1_v_ff;
         if (p3_ready) p3_v_ff <= p2_v_ff;
         if (p4_ready) p4_v_ff <= p3_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (p0_ready) begin
         p0_ff <= in_data;
      end
      if (p1_ready) begin
         p1_ff     <= p0_ff;
         p1_zdx_ff <= gpsb_pkg::ZD_W'(p0_ff.z) * gpsb_pkg::ZD_W'(p0_ff.du_mag);
         p1_zdy_ff <= gpsb_pkg::ZD_W'(p0_ff.z) * gpsb_pkg::ZD_W'(p0_ff.dv_mag);
      end
      if (p2_ready) begin
         p2_ff     <= p1_ff;
         p2_xlo_ff <= gpsb_pkg::PP_W'(p1_zdx_ff)
                    * gpsb_pkg::PP_W'(inv_focal_x_q24[gpsb_pkg::FH_W-1:0]);
         p2_xhi_ff <= gpsb_pkg::PP_W'(p1_zdx_ff)
                    * gpsb_pkg::PP_W'(inv_focal_x_q24[gpsb_pkg::FOC_W-1:gpsb_pkg::FH_W]);
         p2_ylo_ff <= gpsb_pkg::PP_W'(p1_zdy_ff)
                    * gpsb_pkg::PP_W'(inv_focal_y_q24[gpsb_pkg::FH_W-1:0]);
         p2_yhi_ff <= gpsb_pkg::PP_W'(p1_zdy_ff)
                    * gpsb_pkg::PP_W'(inv_focal_y_q24[gpsb_pkg::FOC_W-1:gpsb_pkg::FH_W]);
      end
      if (p3_ready) begin
         p3_ff      <= p2_ff;
         p3_magx_ff <= sumx_in[gpsb_pkg::SUM_W-1:16];
         p3_magy_ff <= sumy_in[gpsb_pkg::SUM_W-1:16];
      end
      if (p4_ready) begin
         p4_ff.pixel_col   <= p3_ff.pixel_col;
         p4_ff.pixel_row   <= p3_ff.pixel_row;
         p4_ff.point_x_q16 <= x_in;
         p4_ff.point_y_q16 <= y_in;
         p4_ff.point_z_q16 <= p3_ff.z;
         p4_ff.pixel_gray  <= p3_ff.pixel_gray;
      end
   end

   assign out_valid = p4_v_ff;
   assign out_data  = p4_ff;

endmodule

>>> rtl/gradient_point_select_backproject.sv
// Gradient point selector with pinhole back-projection, top level.
//
// Takes one gray/depth pixel per clock when not stalled, in raster order, and
// returns in raster order each inner pixel whose squared central-difference
// gradient reaches the squared threshold, with its position, gray value and
// camera-frame point. The pixel at (col, row-1) is judged when the pixel below
// it is accepted; its result then passes registers s1-s3 and p0-p4 and leaves.
// Sustained rate is one pixel per clock when not stalled: line stores are read
// and written once per pixel, and every arithmetic step has its own pipeline
// register. After reset the line stores are swept to zero, one column per cycle,
// so no pixel is taken until all MAX_WIDTH columns are cleared; configuration
// writes are taken at any time but should be made with the pipeline empty.
module gradient_point_select_backproject #(
   parameter int MAX_WIDTH  = gpsb_pkg::MAX_WIDTH_DEF,
   parameter int BORDER     = gpsb_pkg::BORDER_DEF,
   parameter int DEPTH_BITS = gpsb_pkg::DEPTH_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  gpsb_pkg::req_type                  req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output gpsb_pkg::rsp_type                  rsp_data,
   input  logic                               csr_we,
   input  logic [gpsb_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [gpsb_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int CNT_W = $clog2(MAX_WIDTH);
   localparam int CMP_W = ((CNT_W + 2) > 12) ? (CNT_W + 2) : 12;
   localparam int ZP_W  = DEPTH_BITS + gpsb_pkg::FOC_W;
   localparam int ZS_W  = ZP_W - 8;
   localparam int D_W   = gpsb_pkg::D_MAG_W;

   // Configuration registers
   logic [10:0] image_width_ff, image_height_ff;
   logic [8:0]  grad_threshold_ff;
   logic [13:0] center_x_ff, center_y_ff;
   logic [23:0] inv_focal_x_ff, inv_focal_y_ff, inv_depth_scale_ff;
   logic [17:0] thr2_ff;

   // Clearing sweep
   logic             clr_busy_ff;
   logic [CNT_W-1:0] clr_addr_ff;

   // Position counters
   logic [CNT_W-1:0]             col_ff, col_in, c_cur;
   logic [gpsb_pkg::ROW_W-1:0]   row_ff, row_in, r_cur;
   logic [CMP_W-1:0]             w_eff, col_next_w;
   logic [gpsb_pkg::HEIGHT_W-1:0] h_eff, row_next_w;
   logic                         col_last, row_last, win_in;

   // Line stores
   logic [7:0]            gray_row_above_mem  [MAX_WIDTH];
   logic [7:0]            gray_row_center_mem [MAX_WIDTH];
   logic [DEPTH_BITS-1:0] depth_row_center_mem[MAX_WIDTH];

   // s1: accepted pixel
   logic                         s1_v_ff, s1_win_ff;
   logic [CNT_W-1:0]             s1_c_ff, right_addr;
   logic [gpsb_pkg::ROW_W-1:0]   s1_r_ff;
   logic [7:0]                   s1_gray_ff;
   logic [DEPTH_BITS-1:0]        s1_depth_ff;

   // s2: line store data
   logic                         s2_v_ff, s2_win_ff;
   logic [CNT_W-1:0]             s2_c_ff;
   logic [gpsb_pkg::ROW_W-1:0]   s2_r_ff;
   logic [7:0]                   s2_gray_ff;
   logic [7:0]                   above_rd_ff, center_rd_ff, right_rd_ff, left_ff;
   logic [DEPTH_BITS-1:0]        depth_rd_ff;

   // s3: squares, depth product, offsets
   logic                         s3_v_ff, s3_win_ff;
   logic [CNT_W-1:0]             s3_c_ff;
   logic [7:0]                   s3_gray_ff;
   logic [9:0]                   s3_col_ff, s3_row_ff;
   logic [15:0]                  s3_dx2_ff, s3_dy2_ff;
   logic [ZP_W-1:0]              s3_zprod_ff;
   logic [D_W-1:0]               s3_du_ff, s3_dv_ff;
   logic                         s3_du_neg_ff, s3_dv_neg_ff;

   logic s1_ready, s2_ready, s3_ready, req_fire, s1_move, s2_move;
   logic [7:0]                 above_eff;
   logic signed [8:0]          dx, dy;
   logic signed [17:0]         dx_sq, dy_sq;
   logic [D_W-1:0]             col16, row16, cx16, cy16, du_in, dv_in;
   logic                       du_neg_in, dv_neg_in;
   logic [gpsb_pkg::ROW_W-1:0] v_row;
   logic [16:0]                g2;
   logic                       s3_sel;
   logic [ZS_W-1:0]            zsh;
   logic [gpsb_pkg::Z_W-1:0]   z_sat;
   logic                       proj_stall;
   gpsb_pkg::proj_type         proj_in;

   // ---------------------------------------------------------------- config
   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff     <= gpsb_pkg::IMAGE_WIDTH_RST;
         image_height_ff    <= gpsb_pkg::IMAGE_HEIGHT_RST;
         grad_threshold_ff  <= gpsb_pkg::GRAD_THRESHOLD_RST;
         center_x_ff        <= gpsb_pkg::CENTER_X_RST;
         center_y_ff        <= gpsb_pkg::CENTER_Y_RST;
         inv_focal_x_ff     <= gpsb_pkg::INV_FOCAL_X_RST;
         inv_focal_y_ff     <= gpsb_pkg::INV_FOCAL_Y_RST;
         inv_depth_scale_ff <= gpsb_pkg::INV_DEPTH_SCALE_RST;
      end else if (csr_we) begin
         case (csr_index)
            gpsb_pkg::REG_IMAGE_WIDTH:     image_width_ff     <= csr_wdata[10:0];
            gpsb_pkg::REG_IMAGE_HEIGHT:    image_height_ff    <= csr_wdata[10:0];
            gpsb_pkg::REG_GRAD_THRESHOLD:  grad_threshold_ff  <= csr_wdata[8:0];
            gpsb_pkg::REG_CENTER_X_Q4:     center_x_ff        <= csr_wdata[13:0];
            gpsb_pkg::REG_CENTER_Y_Q4:     center_y_ff        <= csr_wdata[13:0];
            gpsb_pkg::REG_INV_FOCAL_X_Q24: inv_focal_x_ff     <= csr_wdata[23:0];
            gpsb_pkg::REG_INV_FOCAL_Y_Q24: inv_focal_y_ff     <= csr_wdata[23:0];
            gpsb_pkg::REG_INV_DEPTH_SCALE: inv_depth_scale_ff <= csr_wdata[23:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      thr2_ff <= 18'(grad_threshold_ff) * 18'(grad_threshold_ff);
   end

   // ---------------------------------------------------------------- clear
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_busy_ff) begin
         if (clr_addr_ff == CNT_W'(MAX_WIDTH - 1)) clr_busy_ff <= 1'b0;
         clr_addr_ff <= clr_addr_ff + 1'b1;
      end
   end

   // ---------------------------------------------------------------- handshake
   assign s3_ready  = !s3_v_ff || !s3_sel || !proj_stall;
   assign s2_ready  = !s2_v_ff || s3_ready;
   assign s1_ready  = !s1_v_ff || s2_ready;
   assign req_stall = clr_busy_ff || !s1_ready;
   assign req_fire  = req_valid && !req_stall;
   assign s1_move   = s1_v_ff && s2_ready;
   assign s2_move   = s2_v_ff && s3_ready;

   // ---------------------------------------------------------------- counters
   always_comb begin
      if (image_width_ff == '0) begin
         w_eff = CMP_W'(1);
      end else if (CMP_W'(image_width_ff) > CMP_W'(MAX_WIDTH)) begin
         w_eff = CMP_W'(MAX_WIDTH);
      end else begin
         w_eff = CMP_W'(image_width_ff);
      end
      if (image_height_ff == '0) begin
         h_eff = gpsb_pkg::HEIGHT_W'(1);
      end else if (image_height_ff > gpsb_pkg::HEIGHT_W'(gpsb_pkg::ROW_LIMIT)) begin
         h_eff = gpsb_pkg::HEIGHT_W'(gpsb_pkg::ROW_LIMIT);
      end else begin
         h_eff = image_height_ff;
      end
   end

   assign c_cur      = req_data.frame_start ? '0 : col_ff;
   assign r_cur      = req_data.frame_start ? '0 : row_ff;
   assign col_next_w = CMP_W'(c_cur) + CMP_W'(1);
   assign row_next_w = gpsb_pkg::HEIGHT_W'(r_cur) + gpsb_pkg::HEIGHT_W'(1);
   assign col_last   = col_next_w >= w_eff;
   assign row_last   = row_next_w >= h_eff;
   assign col_in     = col_last ? '0 : col_next_w[CNT_W-1:0];
   assign row_in     = col_last ? (row_last ? '0 : row_next_w[gpsb_pkg::ROW_W-1:0]) : r_cur;

   assign win_in = (CMP_W'(c_cur) >= CMP_W'(BORDER))
                && (CMP_W'(c_cur) + CMP_W'(BORDER) < w_eff)
                && (CMP_W'(r_cur) >= CMP_W'(BORDER + 1))
                && (CMP_W'(r_cur) + CMP_W'(BORDER - 1) < CMP_W'(h_eff));

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (req_fire) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // ---------------------------------------------------------------- s1
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_v_ff <= req_fire;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && req_fire) begin
         s1_c_ff     <= c_cur;
         s1_r_ff     <= r_cur;
         s1_win_ff   <= win_in;
         s1_gray_ff  <= req_data.gray_value;
         s1_depth_ff <= req_data.depth_raw[DEPTH_BITS-1:0];
      end
   end

   // right neighbor only matters inside the border; keep the address in range
   assign right_addr = (s1_c_ff == CNT_W'(MAX_WIDTH - 1)) ? s1_c_ff : s1_c_ff + 1'b1;

   // ---------------------------------------------------------------- line stores
   always_ff @(posedge clock) begin
      if (s2_ready) begin
         center_rd_ff <= gray_row_center_mem[s1_c_ff];
         right_rd_ff  <= gray_row_center_mem[right_addr];
         depth_rd_ff  <= depth_row_center_mem[s1_c_ff];
      end
      if (clr_busy_ff) begin
         gray_row_center_mem[clr_addr_ff]  <= '0;
         depth_row_center_mem[clr_addr_ff] <= '0;
      end else if (s1_move) begin
         gray_row_center_mem[s1_c_ff]  <= s1_gray_ff;
         depth_row_center_mem[s1_c_ff] <= s1_depth_ff;
      end
   end

   // the row above is written one stage later, from the center read
   always_ff @(posedge clock) begin
      if (s2_ready) begin
         above_rd_ff <= gray_row_above_mem[s1_c_ff];
      end
      if (clr_busy_ff) begin
         gray_row_above_mem[clr_addr_ff] <= '0;
      end else if (s2_move) begin
         gray_row_above_mem[s2_c_ff] <= center_rd_ff;
      end
   end

   // ---------------------------------------------------------------- s2
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
         left_ff <= '0;
      end else begin
         if (s2_ready) s2_v_ff <= s1_v_ff;
         if (s2_move)  left_ff <= center_rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_ready) begin
         s2_c_ff    <= s1_c_ff;
         s2_r_ff    <= s1_r_ff;
         s2_win_ff  <= s1_win_ff;
         s2_gray_ff <= s1_gray_ff;
      end
   end

   // forward the above write of the previous pixel when it hit the same column
   assign above_eff = (s3_v_ff && (s3_c_ff == s2_c_ff)) ? s3_gray_ff : above_rd_ff;

   assign dx    = $signed({1'b0, right_rd_ff}) - $signed({1'b0, left_ff});
   assign dy    = $signed({1'b0, s2_gray_ff}) - $signed({1'b0, above_eff});
   assign dx_sq = dx * dx;
   assign dy_sq = dy * dy;

   assign v_row     = s2_r_ff - 1'b1;
   assign col16     = D_W'(s2_c_ff) << 4;
   assign row16     = D_W'(v_row) << 4;
   assign cx16      = D_W'(center_x_ff);
   assign cy16      = D_W'(center_y_ff);
   assign du_neg_in = col16 < cx16;
   assign dv_neg_in = row16 < cy16;
   assign du_in     = du_neg_in ? cx16 - col16 : col16 - cx16;
   assign dv_in     = dv_neg_in ? cy16 - row16 : row16 - cy16;

   // ---------------------------------------------------------------- s3
   always_ff @(posedge clock) begin
      if (reset) begin
         s3_v_ff <= 1'b0;
      end else if (s3_ready) begin
         s3_v_ff <= s2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_ready) begin
         s3_c_ff      <= s2_c_ff;
         s3_win_ff    <= s2_win_ff;
         s3_gray_ff   <= center_rd_ff;
         s3_col_ff    <= 10'(s2_c_ff);
         s3_row_ff    <= 10'(v_row);
         s3_dx2_ff    <= dx_sq[15:0];
         s3_dy2_ff    <= dy_sq[15:0];
         s3_zprod_ff  <= ZP_W'(depth_rd_ff) * ZP_W'(inv_depth_scale_ff);
         s3_du_ff     <= du_in;
         s3_dv_ff     <= dv_in;
         s3_du_neg_ff <= du_neg_in;
         s3_dv_neg_ff <= dv_neg_in;
      end
   end

   assign g2     = 17'(s3_dx2_ff) + 17'(s3_dy2_ff);
   assign s3_sel = s3_win_ff && (18'(g2) >= thr2_ff);
   assign zsh    = s3_zprod_ff[ZP_W-1:8];
   assign z_sat  = (zsh > ZS_W'(gpsb_pkg::Z_MAX)) ? gpsb_pkg::Z_MAX : zsh[gpsb_pkg::Z_W-1:0];

   always_comb begin
      proj_in.pixel_col  = s3_col_ff;
      proj_in.pixel_row  = s3_row_ff;
      proj_in.pixel_gray = s3_gray_ff;
      proj_in.z          = z_sat;
      proj_in.du_mag     = s3_du_ff;
      proj_in.du_neg     = s3_du_neg_ff;
      proj_in.dv_mag     = s3_dv_ff;
      proj_in.dv_neg     = s3_dv_neg_ff;
   end

   // unselected pixels drop here
   gpsb_project u_project (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (s3_v_ff && s3_sel),
      .in_stall        (proj_stall),
      .in_data         (proj_in),
      .out_valid       (rsp_valid),
      .out_stall       (rsp_stall),
      .out_data        (rsp_data),
      .inv_focal_x_q24 (inv_focal_x_ff),
      .inv_focal_y_q24 (inv_focal_y_ff)
   );

endmodule

>>> bench/tb_gradient_point_select_backproject.sv
// Self-checking bench for the gradient point selector with pinhole back-projection.
`timescale 1ns / 100ps

module tb_gradient_point_select_backproject;

   localparam int MAX_W = gpsb_pkg::MAX_WIDTH_DEF;
   localparam int BORDER = gpsb_pkg::BORDER_DEF;
   localparam int unsigned RANDOM_TARGET = 1500;
   localparam int unsigned DRAIN_LIMIT = 5000;
   localparam int unsigned SETTLE_CYCLES = 24;
   localparam int unsigned CYCLE_LIMIT = 2000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   gpsb_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   gpsb_pkg::rsp_type rsp_data;
   logic csr_we = 1'b0;
   logic [gpsb_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [gpsb_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   // Predictor copy of the registers
   logic [10:0] cfg_width = gpsb_pkg::IMAGE_WIDTH_RST;
   logic [10:0] cfg_height = gpsb_pkg::IMAGE_HEIGHT_RST;
   logic [8:0] cfg_threshold = gpsb_pkg::GRAD_THRESHOLD_RST;
   logic [13:0] cfg_center_x = gpsb_pkg::CENTER_X_RST;
   logic [13:0] cfg_center_y = gpsb_pkg::CENTER_Y_RST;
   logic [23:0] cfg_inv_fx = gpsb_pkg::INV_FOCAL_X_RST;
   logic [23:0] cfg_inv_fy = gpsb_pkg::INV_FOCAL_Y_RST;
   logic [23:0] cfg_inv_depth = gpsb_pkg::INV_DEPTH_SCALE_RST;

   // Predictor copy of the line stores and position
   bit [7:0] gray_above_mem [MAX_W];
   bit [7:0] gray_center_mem [MAX_W];
   bit [15:0] depth_center_mem [MAX_W];
   int unsigned col_cnt = 0;
   int unsigned row_cnt = 0;
   bit [7:0] left_gray = 8'd0;

   gpsb_pkg::req_type pending_pixels [$];
   gpsb_pkg::rsp_type expected_points [$];
   int unsigned pixels_queued = 0;
   int unsigned pixels_accepted = 0;
   int unsigned points_seen = 0;
   int unsigned mismatch_count = 0;
   int unsigned cycle_count = 0;

   int unsigned burst_left = 0;
   int unsigned gap_left = 0;
   int unsigned stall_mode = 0;
   int unsigned stall_segment = 0;
   int unsigned stall_hold = 0;
   logic [7:0] shade = 8'd128;
   gpsb_pkg::rsp_type got_point;
   gpsb_pkg::rsp_type want_point;

   gradient_point_select_backproject i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // z * (16*pos - center) * inv_focal / 2^28, truncated toward zero and saturated
   function automatic logic [23:0] project_lateral(input longint unsigned z,
         input int unsigned pos, input logic [13:0] center, input logic [23:0] inv_focal);
      longint unsigned p16, offset, mag;
      bit neg;
      p16 = pos * 16;
      neg = p16 < center;
      offset = neg ? center - p16 : p16 - center;
      mag = (z * offset * inv_focal) >> 28;
      if (neg) begin
         if (mag > gpsb_pkg::XY_NEG_MAX) mag = gpsb_pkg::XY_NEG_MAX;
         return 24'(0 - mag);
      end
      if (mag > gpsb_pkg::XY_POS_MAX) mag = gpsb_pkg::XY_POS_MAX;
      return 24'(mag);
   endfunction

   // Judge the pixel above the incoming one and advance the line stores
   task automatic judge_pixel(input gpsb_pkg::req_type px);
      int unsigned w, h, c, r, v;
      int dx, dy;
      bit [7:0] above, center, right;
      longint unsigned z;
      gpsb_pkg::rsp_type point;
      w = cfg_width;
      h = cfg_height;
      if (w < 1) w = 1;
      if (w > MAX_W) w = MAX_W;
      if (h < 1) h = 1;
      if (h > gpsb_pkg::ROW_LIMIT) h = gpsb_pkg::ROW_LIMIT;
      if (px.frame_start) begin
         col_cnt = 0;
         row_cnt = 0;
      end
      c = col_cnt % MAX_W;
      r = row_cnt % gpsb_pkg::ROW_LIMIT;
      above = gray_above_mem[c];
      center = gray_center_mem[c];
      right = (c + 1 < MAX_W) ? gray_center_mem[c + 1] : 8'd0;
      if (c >= BORDER && c + BORDER < w && r >= BORDER + 1 && r - 1 + BORDER < h) begin
         dx = int'(right) - int'(left_gray);
         dy = int'(px.gray_value) - int'(above);
         if (dx * dx + dy * dy >= int'(cfg_threshold) * int'(cfg_threshold)) begin
            v = r - 1;
            z = depth_center_mem[c];
            z = (z * cfg_inv_depth) >> 8;
            if (z > gpsb_pkg::Z_MAX) z = gpsb_pkg::Z_MAX;
            point.pixel_col = 10'(c);
            point.pixel_row = 10'(v);
            point.point_x_q16 = project_lateral(z, c, cfg_center_x, cfg_inv_fx);
            point.point_y_q16 = project_lateral(z, v, cfg_center_y, cfg_inv_fy);
            point.point_z_q16 = 23'(z);
            point.pixel_gray = center;
            expected_points.insert(expected_points.size(), point);
         end
      end
      left_gray = center;
      gray_above_mem[c] = center;
      gray_center_mem[c] = px.gray_value;
      depth_center_mem[c] = px.depth_raw;
      if (c + 1 >= w) begin
         col_cnt = 0;
         row_cnt = (r + 1 >= h) ? 0 : r + 1;
      end else begin
         col_cnt = c + 1;
         row_cnt = r;
      end
   endtask

   task automatic check_field(input string field, input logic [23:0] want,
         input logic [23:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
         mismatch_count++;
      end
   endtask

   task automatic write_reg(input logic [gpsb_pkg::CSR_IDX_W-1:0] index,
         input logic [gpsb_pkg::CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (index)
         gpsb_pkg::REG_IMAGE_WIDTH:     cfg_width = value[10:0];
         gpsb_pkg::REG_IMAGE_HEIGHT:    cfg_height = value[10:0];
         gpsb_pkg::REG_GRAD_THRESHOLD:  cfg_threshold = value[8:0];
         gpsb_pkg::REG_CENTER_X_Q4:     cfg_center_x = value[13:0];
         gpsb_pkg::REG_CENTER_Y_Q4:     cfg_center_y = value[13:0];
         gpsb_pkg::REG_INV_FOCAL_X_Q24: cfg_inv_fx = value;
         gpsb_pkg::REG_INV_FOCAL_Y_Q24: cfg_inv_fy = value;
         gpsb_pkg::REG_INV_DEPTH_SCALE: cfg_inv_depth = value;
         default: ;
      endcase
   endtask

   task automatic setup_registers(input int unsigned width, input int unsigned height,
         input int unsigned threshold, input int unsigned cx, input int unsigned cy,
         input int unsigned inv_fx, input int unsigned inv_fy, input int unsigned inv_depth);
      write_reg(gpsb_pkg::REG_IMAGE_WIDTH, gpsb_pkg::CSR_DATA_W'(width));
      write_reg(gpsb_pkg::REG_IMAGE_HEIGHT, gpsb_pkg::CSR_DATA_W'(height));
      write_reg(gpsb_pkg::REG_GRAD_THRESHOLD, gpsb_pkg::CSR_DATA_W'(threshold));
      write_reg(gpsb_pkg::REG_CENTER_X_Q4, gpsb_pkg::CSR_DATA_W'(cx));
      write_reg(gpsb_pkg::REG_CENTER_Y_Q4, gpsb_pkg::CSR_DATA_W'(cy));
      write_reg(gpsb_pkg::REG_INV_FOCAL_X_Q24, gpsb_pkg::CSR_DATA_W'(inv_fx));
      write_reg(gpsb_pkg::REG_INV_FOCAL_Y_Q24, gpsb_pkg::CSR_DATA_W'(inv_fy));
      write_reg(gpsb_pkg::REG_INV_DEPTH_SCALE, gpsb_pkg::CSR_DATA_W'(inv_depth));
   endtask

   // Bounds, uniform values, and values skewed toward the low end
   function automatic int unsigned pick_value(input int unsigned lo, input int unsigned hi);
      int unsigned v;
      case ($urandom_range(0, 7))
         0: return lo;
         1: return hi;
         2, 3: return $urandom_range(lo, hi);
         default: begin
            v = $urandom_range(lo, hi) >> $urandom_range(0, 12);
            return (v < lo) ? lo : v;
         end
      endcase
   endfunction

   task automatic push_pixel(input logic [7:0] gray, input logic [15:0] depth, input bit start);
      gpsb_pkg::req_type px;
      px.gray_value = gray;
      px.depth_raw = depth;
      px.frame_start = start;
      pending_pixels.insert(pending_pixels.size(), px);
      pixels_queued++;
   endtask

   // Mix noisy and smooth gray so that both sides of the threshold show up
   task automatic queue_pixels(input int unsigned count, input bit first_start,
         input int unsigned start_odds);
      logic [15:0] depth;
      bit start;
      for (int unsigned i = 0; i < count; i++) begin
         shade = ($urandom_range(0, 2) == 0) ? 8'($urandom)
                                              : shade + 8'($urandom_range(0, 8)) - 8'd4;
         case ($urandom_range(0, 9))
            0: depth = 16'd0;
            1: depth = 16'hFFFF;
            default: depth = 16'($urandom);
         endcase
         if (i == 0) start = first_start;
         else start = (start_odds != 0) && ($urandom_range(1, start_odds) == 1);
         push_pixel(shade, depth, start);
      end
   endtask

   // Hold until every pixel is in and every point is out, then let the pipe settle
   task automatic wait_drained();
      int unsigned waited;
      waited = 0;
      while (pixels_accepted != pixels_queued) @(posedge clock);
      while (expected_points.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (expected_points.size() != 0) begin
         $display("%0t: %0d points missing, expected col %0d row %0d, actual none", $time,
                  expected_points.size(), expected_points[0].pixel_col,
                  expected_points[0].pixel_row);
         mismatch_count++;
         expected_points.delete();
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Sender: bursts of transfers with idle gaps between them
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         burst_left = 0;
         gap_left = 0;
      end else begin
         if (req_valid && !req_stall) begin
            judge_pixel(req_data);
            pixels_accepted++;
         end
         if (!req_valid || !req_stall) begin
            if (gap_left != 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_pixels.size() != 0) begin
               req_data <= pending_pixels.pop_front();
               req_valid <= 1'b1;
               if (burst_left <= 1) begin
                  burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 400)
                                                           : $urandom_range(1, 40);
                  gap_left = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 10);
               end else begin
                  burst_left--;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: check each transfer and stall in segments of differing character
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got_point = rsp_data;
            points_seen++;
            if (expected_points.size() == 0) begin
               $display("%0t: unexpected point, expected none, actual col %0d row %0d",
                        $time, got_point.pixel_col, got_point.pixel_row);
               mismatch_count++;
            end else begin
               want_point = expected_points.pop_front();
               check_field("pixel_col", want_point.pixel_col, got_point.pixel_col);
               check_field("pixel_row", want_point.pixel_row, got_point.pixel_row);
               check_field("point_x_q16", want_point.point_x_q16, got_point.point_x_q16);
               check_field("point_y_q16", want_point.point_y_q16, got_point.point_y_q16);
               check_field("point_z_q16", want_point.point_z_q16, got_point.point_z_q16);
               check_field("pixel_gray", want_point.pixel_gray, got_point.pixel_gray);
            end
         end
         if (stall_segment == 0) begin
            stall_mode = $urandom_range(0, 2);
            stall_segment = $urandom_range(20, 300);
         end
         stall_segment--;
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 2) == 0);
            default: begin
               if (stall_hold != 0) begin
                  stall_hold--;
                  rsp_stall <= 1'b1;
               end else if ($urandom_range(0, 9) == 0) begin
                  stall_hold = $urandom_range(0, 7);
                  rsp_stall <= 1'b1;
               end else begin
                  rsp_stall <= 1'b0;
               end
            end
         endcase
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles", $time, cycle_count);
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      int unsigned random_pixels, kind, width, height, count, odds;
      bit open_frame;
      random_pixels = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // One-pixel frame: every pixel is its own frame, field extremes
      setup_registers(0, 0, 0, 0, 16383, 1, 16777215, 16777215);
      push_pixel(8'd0, 16'd0, 1'b1);
      push_pixel(8'd255, 16'hFFFF, 1'b0);
      push_pixel(8'd0, 16'hFFFF, 1'b1);
      push_pixel(8'd255, 16'd0, 1'b0);
      push_pixel(8'hAA, 16'hAAAA, 1'b0);
      push_pixel(8'h55, 16'h5555, 1'b1);
      wait_drained();

      // Frame too small for the border: nothing may be selected
      setup_registers(5, 3, 362, 16383, 0, 16777215, 1, 1);
      for (int i = 0; i < 16; i++)
         push_pixel((i % 2 == 0) ? 8'd255 : 8'd0, (i % 3 == 0) ? 16'hFFFF : 16'd0, i == 0);
      wait_drained();

      while (random_pixels < RANDOM_TARGET) begin
         kind = $urandom_range(0, 9);
         width = $urandom_range(21, 40);
         height = $urandom_range(21, 26);
         if (kind == 9) begin
            width = pick_value(0, 2047);
            height = pick_value(0, 2047);
         end
         setup_registers(width, height,
                         ($urandom_range(0, 4) == 0) ? pick_value(0, 511)
                                                     : $urandom_range(0, 80),
                         pick_value(0, 16383), pick_value(0, 16383),
                         pick_value(1, 16777215), pick_value(1, 16777215),
                         pick_value(1, 16777215));
         case (kind)
            0, 1, 2, 3: begin
               // Stop after the last row that can still hold a selected pixel
               count = (height - 9) * width;
               open_frame = 1'b1;
               odds = 0;
            end
            4, 5: begin
               // Second frame, if any, runs on without a start marker
               count = width * height * $urandom_range(1, 2);
               open_frame = 1'b1;
               odds = 0;
            end
            6, 7: begin
               count = $urandom_range(50, 800);
               open_frame = 1'b0;
               odds = 40;
            end
            default: begin
               count = $urandom_range(100, 400);
               open_frame = ($urandom_range(0, 1) == 1);
               odds = 20;
            end
         endcase
         // Keep the run near its pixel budget
         if (count > RANDOM_TARGET - random_pixels) count = RANDOM_TARGET - random_pixels;
         queue_pixels(count, open_frame, odds);
         random_pixels += count;
         wait_drained();
      end

      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

>>> gradient_point_select_backproject.f
rtl/gpsb_pkg.sv
rtl/gpsb_project.sv
rtl/gradient_point_select_backproject.sv
bench/tb_gradient_point_select_backproject.sv
